// ----- hdl/cbhs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbhs_pkg
// Shared types and codes for the clamped bilinear height sampler.
// ----------------------------------------------------------------------------
package cbhs_pkg;

   localparam int DEFAULT_MAX_DIM = 256;

   localparam int COORD_W  = 20;
   localparam int FRAC_W   = 8;
   localparam int HEIGHT_W = 16;
   localparam int VALUE_W  = 24;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 2;
   localparam int DIM_W    = 9;
   localparam int WGT_W    = 17;
   localparam int ACC_W    = 32;
   localparam int CORNER_W = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from the word address bit
   localparam logic CSR_IDX_MAP_WIDTH = 1'b0;
   localparam logic CSR_IDX_MAP_DEPTH = 1'b1;

   // Request kinds; the unused code reads like a point read
   localparam logic [KIND_W-1:0] REQ_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_SAMPLE = 2'd1;
   localparam logic [KIND_W-1:0] REQ_POINT  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_READ_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_WRITE_STORED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_WRITE_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_MAP_EMPTY    = 2'd3;

   // Corner order of a sample: bit 0 selects the right column, bit 1 the lower row
   localparam logic [CORNER_W-1:0] CORNER_FIRST = 2'd0;
   localparam logic [CORNER_W-1:0] CORNER_LAST  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]          req_type;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_z;
      logic [HEIGHT_W-1:0]        height_value;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  result_value;
      logic [STATUS_W-1:0] status;
   } rsp_item_type;

   // What an item needs from the height store
   typedef enum logic [1:0] {
      JOB_SAMPLE = 2'd0,
      JOB_POINT  = 2'd1,
      JOB_WRITE  = 2'd2,
      JOB_REPORT = 2'd3
   } job_type;

   typedef struct packed {
      logic                capture;
      logic                read;
      logic [CORNER_W-1:0] corner;
      logic                finish;
      logic                write;
   } dp_cmd_type;

   typedef struct packed {
      job_type job_in;
      job_type job;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- hdl/cbhs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbhs_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module cbhs_ram #(
   parameter int WIDTH = cbhs_pkg::HEIGHT_W,
   parameter int DEPTH = cbhs_pkg::DEFAULT_MAX_DIM * cbhs_pkg::DEFAULT_MAX_DIM
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/cbhs_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbhs_dpath
// Coordinate clamp, address and weight generation, height store and blend.
// ----------------------------------------------------------------------------
module cbhs_dpath #(
   parameter int MAX_DIM = cbhs_pkg::DEFAULT_MAX_DIM
) (
   input  wire logic                         clock,
   input  wire cbhs_pkg::dp_cmd_type         cmd,
   output cbhs_pkg::dp_status_type           status,
   input  wire cbhs_pkg::req_item_type       req_data,
   input  wire logic [cbhs_pkg::DIM_W-1:0]   map_width,
   input  wire logic [cbhs_pkg::DIM_W-1:0]   map_depth,
   output cbhs_pkg::rsp_item_type            rsp_data
);

   import cbhs_pkg::*;

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int DIM_MAX = (1 << DIM_W) - 1;
   localparam int DIM_CAP = (MAX_DIM > DIM_MAX) ? DIM_MAX : MAX_DIM;
   localparam int INT_W   = COORD_W - FRAC_W;
   localparam int LIN_W   = 2 * DIM_W;

   typedef struct packed {
      logic [DIM_W-1:0]  idx;
      logic [FRAC_W-1:0] frac;
   } axis_type;

   // Clamp a fixed-point coordinate to 0 .. (lim-1) in whole cells
   function automatic axis_type clamp_axis(input logic [COORD_W-1:0] c,
                                           input logic [DIM_W-1:0]   lim);
      axis_type r;
      if (c[COORD_W-1]) begin
         r.idx  = '0;
         r.frac = '0;
      end else if (c[COORD_W-2:FRAC_W] >= (INT_W-1)'(lim)) begin
         r.idx  = lim - DIM_W'(1);
         r.frac = '0;
      end else begin
         r.idx  = c[FRAC_W+DIM_W-1:FRAC_W];
         r.frac = c[FRAC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic in_map(input logic [COORD_W-1:0] c,
                                   input logic [DIM_W-1:0]   lim);
      return !c[COORD_W-1] && (c[COORD_W-2:FRAC_W] < (INT_W-1)'(lim));
   endfunction

   logic [DIM_W-1:0] w_eff, d_eff;
   logic             empty, write_ok;
   axis_type         ax, az;
   job_type          job_in;
   logic [STATUS_W-1:0] stat_in;

   job_type             job_ff;
   logic [STATUS_W-1:0] stat_ff;
   logic [DIM_W-1:0]    ix_ff, iz_ff;
   logic [FRAC_W-1:0]   fx_ff, fz_ff;
   logic [HEIGHT_W-1:0] hv_ff;
   logic [WGT_W-1:0]    wgt_ff, wgt_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   rsp_item_type        rsp_ff, rsp_in;

   logic [DIM_W-1:0]    x1, z1, x_sel, z_sel;
   logic [DIM_W-1:0]    wx_sel, wz_sel;
   logic [LIN_W-1:0]    row_base, lin_addr;
   logic [2*DIM_W-1:0]  wprod;
   logic [ADDR_W-1:0]   ram_addr;
   logic [HEIGHT_W-1:0] rd_data;
   logic [HEIGHT_W+WGT_W-1:0] prod;
   logic [ACC_W-1:0]    sum;

   // Register values above the store size act as the store size
   assign w_eff = (map_width > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : map_width;
   assign d_eff = (map_depth > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : map_depth;

   assign empty    = (w_eff == '0) || (d_eff == '0);
   assign ax       = clamp_axis(req_data.coord_x, w_eff);
   assign az       = clamp_axis(req_data.coord_z, d_eff);
   assign write_ok = in_map(req_data.coord_x, w_eff) && in_map(req_data.coord_z, d_eff);

   always_comb begin
      if (empty) begin
         job_in  = JOB_REPORT;
         stat_in = STAT_MAP_EMPTY;
      end else begin
         case (req_data.req_type)
            REQ_WRITE: begin
               job_in  = write_ok ? JOB_WRITE : JOB_REPORT;
               stat_in = write_ok ? STAT_WRITE_STORED : STAT_WRITE_RANGE;
            end
            REQ_SAMPLE: begin
               job_in  = JOB_SAMPLE;
               stat_in = STAT_READ_DONE;
            end
            default: begin
               job_in  = JOB_POINT;
               stat_in = STAT_READ_DONE;
            end
         endcase
      end
   end

   // Far neighbors stop at the last column and row
   assign x1 = (ix_ff == w_eff - DIM_W'(1)) ? ix_ff : ix_ff + DIM_W'(1);
   assign z1 = (iz_ff == d_eff - DIM_W'(1)) ? iz_ff : iz_ff + DIM_W'(1);

   assign x_sel  = cmd.corner[0] ? x1 : ix_ff;
   assign z_sel  = cmd.corner[1] ? z1 : iz_ff;
   assign wx_sel = cmd.corner[0] ? DIM_W'(fx_ff) : DIM_W'(1 << FRAC_W) - DIM_W'(fx_ff);
   assign wz_sel = cmd.corner[1] ? DIM_W'(fz_ff) : DIM_W'(1 << FRAC_W) - DIM_W'(fz_ff);

   assign row_base = z_sel * w_eff;
   assign lin_addr = row_base + LIN_W'(x_sel);
   assign ram_addr = ADDR_W'(lin_addr);
   assign wprod    = wx_sel * wz_sel;
   assign wgt_in   = wprod[WGT_W-1:0];

   cbhs_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.write),
      .rd_en   (cmd.read),
      .addr    (ram_addr),
      .wr_data (hv_ff),
      .rd_data (rd_data)
   );

   // Data of the previous corner meets its weight here
   assign prod = rd_data * wgt_ff;
   assign sum  = acc_ff + prod[ACC_W-1:0];

   assign acc_in = (cmd.corner == CORNER_FIRST) ? '0 : sum;

   always_comb begin
      rsp_in.status = stat_ff;
      if ((job_ff == JOB_SAMPLE) || (job_ff == JOB_POINT)) begin
         rsp_in.result_value = sum[ACC_W-1:FRAC_W];
      end else begin
         rsp_in.result_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         job_ff  <= job_in;
         stat_ff <= stat_in;
         ix_ff   <= ax.idx;
         iz_ff   <= az.idx;
         fx_ff   <= (req_data.req_type == REQ_SAMPLE) ? ax.frac : '0;
         fz_ff   <= (req_data.req_type == REQ_SAMPLE) ? az.frac : '0;
         hv_ff   <= req_data.height_value;
      end
      if (cmd.read) begin
         wgt_ff <= wgt_in;
         acc_ff <= acc_in;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.job_in = job_in;
   assign status.job    = job_ff;
   assign rsp_data      = rsp_ff;

endmodule
`default_nettype wire

// ----- hdl/cbhs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbhs_ctrl
// Sequencer: item accept, corner reads, result register handshake.
// ----------------------------------------------------------------------------
module cbhs_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire cbhs_pkg::dp_status_type   status,
   output cbhs_pkg::dp_cmd_type           cmd
);

   import cbhs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_READ   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [CORNER_W-1:0] corner_ff, corner_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                capture, out_load;
   logic [CORNER_W-1:0] last_corner;

   assign capture     = (state_ff == S_IDLE) && req_valid;
   assign out_load    = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign last_corner = (status.job == JOB_SAMPLE) ? CORNER_LAST : CORNER_FIRST;

   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               corner_in = CORNER_FIRST;
               case (status.job_in) inside
                  JOB_SAMPLE, JOB_POINT: state_in = S_READ;
                  default:               state_in = S_FINISH;
               endcase
            end
         end
         S_READ: begin
            if (corner_ff == last_corner) begin
               state_in = S_FINISH;
            end else begin
               corner_in = corner_ff + CORNER_W'(1);
            end
         end
         S_FINISH: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         corner_ff    <= CORNER_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.capture = capture;
   assign cmd.read    = (state_ff == S_READ);
   assign cmd.corner  = corner_ff;
   assign cmd.finish  = out_load;
   assign cmd.write   = out_load && (status.job == JOB_WRITE);

   // Hold off items while reset is applied
   assign req_stall = (state_ff != S_IDLE) || reset;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- hdl/clamped_bilinear_height_sampler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_bilinear_height_sampler
// Height map with writes, clamped point reads and clamped bilinear samples.
// ----------------------------------------------------------------------------
//
//   channel   handshake             payload
//   --------  --------------------  ------------------------------------------
//   req       req_valid/req_stall   req_type, coord_x, coord_z, height_value
//   rsp       rsp_valid/rsp_stall   result_value, status
//   csr       psel/penable/pwrite   map_width (0x0), map_depth (0x4)
//
// A sample makes four corner reads through the single port of the height
// store, then the blend; a point read makes one read, and a write or an item
// that is answered from its status only makes none.
// Reset is synchronous; it clears the sequencer and both map size registers.
// The height store is not cleared: an entry reads as undefined until written.
// A finished result waits in the output register while the next item is
// accepted; that item holds in its last step until the register is taken.
// ----------------------------------------------------------------------------
module clamped_bilinear_height_sampler #(
   parameter int MAX_DIM = cbhs_pkg::DEFAULT_MAX_DIM
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire cbhs_pkg::req_item_type            req_data,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output cbhs_pkg::rsp_item_type                 rsp_data,

   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [cbhs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [cbhs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [cbhs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready
);

   import cbhs_pkg::*;

   logic [DIM_W-1:0] map_width_ff, map_width_in;
   logic [DIM_W-1:0] map_depth_ff, map_depth_in;
   logic             csr_write;
   logic             csr_idx;

   dp_cmd_type       cmd;
   dp_status_type    dp_status;

   // Registers sit at word addresses; the word bit picks the register
   assign pready    = 1'b1;
   assign csr_idx   = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      map_width_in = map_width_ff;
      map_depth_in = map_depth_ff;
      if (csr_write) begin
         unique case (csr_idx)
            CSR_IDX_MAP_WIDTH: map_width_in = pwdata[DIM_W-1:0];
            CSR_IDX_MAP_DEPTH: map_depth_in = pwdata[DIM_W-1:0];
            default:           map_width_in = map_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_MAP_WIDTH: prdata = CSR_DATA_W'(map_width_ff);
         CSR_IDX_MAP_DEPTH: prdata = CSR_DATA_W'(map_depth_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff <= '0;
         map_depth_ff <= '0;
      end else begin
         map_width_ff <= map_width_in;
         map_depth_ff <= map_depth_in;
      end
   end

   // Sequencer: accept, step through corners, load the result register
   cbhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (cmd)
   );

   // Clamp, address, weights, height store and accumulate
   cbhs_dpath #(
      .MAX_DIM (MAX_DIM)
   ) u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .status    (dp_status),
      .req_data  (req_data),
      .map_width (map_width_ff),
      .map_depth (map_depth_ff),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- sim/clamped_bilinear_height_sampler_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_bilinear_height_sampler_test
// Loads height maps of several sizes through write items, then checks point
// reads and bilinear samples, clamped at every edge, against a height-map
// scoreboard. Map sizes change between phases over the register port; both
// item channels idle and stall at random.
// ----------------------------------------------------------------------------

class height_map_scoreboard;
   logic [cbhs_pkg::DIM_W-1:0]    map_width;
   logic [cbhs_pkg::DIM_W-1:0]    map_depth;
   bit [cbhs_pkg::HEIGHT_W-1:0]   heights [cbhs_pkg::DEFAULT_MAX_DIM * cbhs_pkg::DEFAULT_MAX_DIM];
   bit                            written [cbhs_pkg::DEFAULT_MAX_DIM * cbhs_pkg::DEFAULT_MAX_DIM];
   cbhs_pkg::rsp_item_type        awaited_results [$];
   int unsigned                   corner [4];
   int unsigned                   frac_x;
   int unsigned                   frac_z;
   int                            errors;

   function new();
      map_width = '0;
      map_depth = '0;
      errors    = 0;
   endfunction

   function void set_map_reg(logic idx, logic [cbhs_pkg::DIM_W-1:0] value);
      if (idx == cbhs_pkg::CSR_IDX_MAP_WIDTH) begin
         map_width = value;
      end else begin
         map_depth = value;
      end
   endfunction

   function int unsigned dim_in_use(logic [cbhs_pkg::DIM_W-1:0] r);
      return (r > cbhs_pkg::DEFAULT_MAX_DIM) ? cbhs_pkg::DEFAULT_MAX_DIM : r;
   endfunction

   function int unsigned cell_index(int unsigned x, int unsigned z);
      int unsigned w, d;
      w = dim_in_use(map_width);
      d = dim_in_use(map_depth);
      if (x >= w) x = w - 1;
      if (z >= d) z = d - 1;
      return x + z * w;
   endfunction

   function int unsigned clamp_fixed(int c, int unsigned lim);
      if (c < 0) return 0;
      if (c >= int'(lim << 8)) return (lim - 1) << 8;
      return c;
   endfunction

   // Fill corner[] with the store entries a request reads; returns how many.
   function int locate_corners(cbhs_pkg::req_item_type r);
      int unsigned w, d, fx, fz, ix, iz;
      int cx, cz;
      w  = dim_in_use(map_width);
      d  = dim_in_use(map_depth);
      cx = $signed(r.coord_x);
      cz = $signed(r.coord_z);
      frac_x = 0;
      frac_z = 0;
      if (w == 0 || d == 0 || r.req_type == cbhs_pkg::REQ_WRITE) return 0;
      if (r.req_type == cbhs_pkg::REQ_SAMPLE) begin
         fx = clamp_fixed(cx, w);
         fz = clamp_fixed(cz, d);
         ix = fx >> 8;
         iz = fz >> 8;
         frac_x = fx & 8'hFF;
         frac_z = fz & 8'hFF;
         corner[0] = cell_index(ix, iz);
         corner[1] = cell_index(ix + 1, iz);
         corner[2] = cell_index(ix, iz + 1);
         corner[3] = cell_index(ix + 1, iz + 1);
         return 4;
      end
      // point read, and the unused code acts as one: floor, then clamp
      ix = (cx < 0) ? 0 : cx >> 8;
      iz = (cz < 0) ? 0 : cz >> 8;
      corner[0] = cell_index(ix, iz);
      return 1;
   endfunction

   function bit can_read(cbhs_pkg::req_item_type r);
      int n;
      n = locate_corners(r);
      for (int i = 0; i < n; i++) begin
         if (!written[corner[i]]) return 0;
      end
      return 1;
   endfunction

   // Work out the result of one request; a write also updates the store.
   function cbhs_pkg::rsp_item_type compute_height_result(cbhs_pkg::req_item_type r);
      cbhs_pkg::rsp_item_type res;
      longint unsigned wx0, wx1, wz0, wz1, blend;
      int unsigned w, d, idx;
      int cx, cz, n;
      res = '0;
      w   = dim_in_use(map_width);
      d   = dim_in_use(map_depth);
      cx  = $signed(r.coord_x);
      cz  = $signed(r.coord_z);
      if (w == 0 || d == 0) begin
         res.status = cbhs_pkg::STAT_MAP_EMPTY;
         return res;
      end
      if (r.req_type == cbhs_pkg::REQ_WRITE) begin
         if (cx < 0 || cz < 0 || (cx >> 8) >= w || (cz >> 8) >= d) begin
            res.status = cbhs_pkg::STAT_WRITE_RANGE;
         end else begin
            idx = (cx >> 8) + (cz >> 8) * w;
            heights[idx] = r.height_value;
            written[idx] = 1'b1;
            res.status = cbhs_pkg::STAT_WRITE_STORED;
         end
         return res;
      end
      n = locate_corners(r);
      if (n == 4) begin
         wx1 = frac_x;
         wz1 = frac_z;
         wx0 = 256 - wx1;
         wz0 = 256 - wz1;
         blend = heights[corner[0]] * wx0 * wz0 + heights[corner[1]] * wx1 * wz0
               + heights[corner[2]] * wx0 * wz1 + heights[corner[3]] * wx1 * wz1;
         blend = blend >> 8;
         res.result_value = blend[cbhs_pkg::VALUE_W-1:0];
      end else begin
         res.result_value = {heights[corner[0]], 8'h00};
      end
      res.status = cbhs_pkg::STAT_READ_DONE;
      return res;
   endfunction

   function void note_request(cbhs_pkg::req_item_type r);
      awaited_results.push_back(compute_height_result(r));
   endfunction

   function void check_result(cbhs_pkg::rsp_item_type got);
      cbhs_pkg::rsp_item_type want;
      if (awaited_results.size() == 0) begin
         errors++;
         $display("%0t unexpected result: expected none, actual value %h status %0d",
                  $time, got.result_value, got.status);
         return;
      end
      want = awaited_results.pop_front();
      if (got.result_value !== want.result_value) begin
         errors++;
         $display("%0t result_value: expected %h, actual %h",
                  $time, want.result_value, got.result_value);
      end
      if (got.status !== want.status) begin
         errors++;
         $display("%0t status: expected %0d, actual %0d", $time, want.status, got.status);
      end
   endfunction

   function int pending();
      return awaited_results.size();
   endfunction
endclass

module clamped_bilinear_height_sampler_test;
   import cbhs_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 8;
   // let a last sample finish before touching registers
   localparam int SETTLE_CYCLES = 12;
   localparam longint RUN_LIMIT_NS = 20_000_000;

   localparam logic [CSR_ADDR_W-1:0] ADDR_MAP_WIDTH = {CSR_IDX_MAP_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAP_DEPTH = {CSR_IDX_MAP_DEPTH, 2'b00};
   // the fourth request code is undefined and reads like a point read
   localparam logic [KIND_W-1:0]     REQ_UNUSED     = 2'd3;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_kind_type;

   typedef struct {
      int unsigned x;
      int unsigned z;
   } cell_pos_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_item_type          rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   height_map_scoreboard board = new();

   int             burst_left  = 0;
   int unsigned    cur_w       = 0;
   int unsigned    cur_d       = 0;
   stall_kind_type stall_mode  = STALL_NONE;
   int unsigned    stall_count = 0;
   // cells written in the current phase; reads aim here on large maps
   cell_pos_type   known_cells [$];

   clamped_bilinear_height_sampler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Result side: check each item taken at this edge, then pick the stall for
   // the next cycle. The stall style is redrawn when its random run ends, so that
   // quiet stretches, light and heavy back-pressure and a fixed rhythm all occur.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_data);
      end
      if (stall_count == 0) begin
         stall_mode  = stall_kind_type'($urandom_range(0, 3));
         stall_count = $urandom_range(20, 80);
      end
      stall_count--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_count % 4 != 0);
      endcase
   end

   // Offer one item and hold it until taken. Items go out in bursts; a burst
   // ends with a gap with valid low, so valid is never dropped and raised
   // in the same step.
   task automatic send_request(input req_item_type item);
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
      burst_left--;
   endtask

   task automatic send_fields(input logic [KIND_W-1:0] kind, input int cx, input int cz,
                              input int unsigned h);
      req_item_type item;
      item.req_type     = kind;
      item.coord_x      = cx[COORD_W-1:0];
      item.coord_z      = cz[COORD_W-1:0];
      item.height_value = h[HEIGHT_W-1:0];
      send_request(item);
   endtask

   // Drop valid and wait until every result is back and the block is quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the
   // edge where the access completes.
   task automatic write_map_reg(input logic [CSR_ADDR_W-1:0] addr, input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_map_reg(addr[CSR_ADDR_W-1], value[DIM_W-1:0]);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_map_size(input int unsigned wreg, input int unsigned dreg);
      wait_idle();
      if ($urandom_range(0, 1)) begin
         write_map_reg(ADDR_MAP_WIDTH, wreg);
         write_map_reg(ADDR_MAP_DEPTH, dreg);
      end else begin
         write_map_reg(ADDR_MAP_DEPTH, dreg);
         write_map_reg(ADDR_MAP_WIDTH, wreg);
      end
      cur_w = board.dim_in_use(board.map_width);
      cur_d = board.dim_in_use(board.map_depth);
      known_cells.delete();
   endtask

   function automatic int unsigned pick_height();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 16'hFFFF;
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   // Coordinate along an axis of lim cells: mostly inside, with a share of
   // negatives, values past the far edge, exact edges and raw 20-bit noise.
   function automatic int pick_coord(input int unsigned lim);
      logic [COORD_W-1:0] raw;
      int unsigned span;
      raw  = $urandom();
      span = lim << 8;
      if (lim == 0) return $signed(raw);
      case ($urandom_range(0, 9))
         0: return $signed(raw);
         1: return -int'($urandom_range(1, 3000));
         2: return span + $urandom_range(0, 3000);
         3: begin
            case ($urandom_range(0, 3))
               0:       return 0;
               1:       return (lim - 1) << 8;
               2:       return span - 1;
               default: return span;
            endcase
         end
         default: return $urandom_range(0, span - 1);
      endcase
   endfunction

   task automatic write_cell(input int unsigned x, input int unsigned z, input int unsigned h);
      cell_pos_type p;
      p.x = x;
      p.z = z;
      known_cells.push_back(p);
      // random fraction bits: the block must drop them
      send_fields(REQ_WRITE, (x << 8) | $urandom_range(0, 255),
                  (z << 8) | $urandom_range(0, 255), h);
   endtask

   task automatic write_block(input int unsigned x0, input int unsigned z0,
                              input int unsigned nx, input int unsigned nz);
      for (int unsigned z = z0; z < z0 + nz && z < cur_d; z++) begin
         for (int unsigned x = x0; x < x0 + nx && x < cur_w; x++) begin
            write_cell(x, z, pick_height());
         end
      end
   endtask

   // Small maps are filled whole. Large ones get the four corner blocks, so
   // clamped reads past any corner land on written cells, plus a few patches.
   task automatic fill_map();
      int unsigned far_x, far_z;
      far_x = (cur_w > 2) ? cur_w - 2 : 0;
      far_z = (cur_d > 2) ? cur_d - 2 : 0;
      if (cur_w * cur_d <= 64) begin
         write_block(0, 0, cur_w, cur_d);
      end else begin
         write_block(0, 0, 2, 2);
         write_block(far_x, 0, 2, 2);
         write_block(0, far_z, 2, 2);
         write_block(far_x, far_z, 2, 2);
         repeat (2) write_block($urandom_range(0, cur_w - 1), $urandom_range(0, cur_d - 1), 3, 3);
      end
   endtask

   task automatic send_random_write();
      int cx, cz;
      int unsigned x, z;
      cell_pos_type p;
      if (cur_w == 0 || cur_d == 0 || $urandom_range(0, 4) == 0) begin
         cx = pick_coord(cur_w);
         cz = pick_coord(cur_d);
      end else begin
         x   = $urandom_range(0, cur_w - 1);
         z   = $urandom_range(0, cur_d - 1);
         p.x = x;
         p.z = z;
         known_cells.push_back(p);
         cx  = (x << 8) | $urandom_range(0, 255);
         cz  = (z << 8) | $urandom_range(0, 255);
      end
      send_fields(REQ_WRITE, cx, cz, pick_height());
   endtask

   // Try free coordinates first, then aim at written cells; never read an
   // entry that was not written. If nothing fits, write instead.
   task automatic send_random_read(input logic [KIND_W-1:0] kind);
      req_item_type item;
      cell_pos_type p;
      int cx, cz;
      item.req_type     = kind;
      item.height_value = $urandom_range(0, 16'hFFFF);
      for (int tries = 0; tries < 16; tries++) begin
         if (tries < 8 || known_cells.size() == 0) begin
            cx = pick_coord(cur_w);
            cz = pick_coord(cur_d);
         end else begin
            p  = known_cells[$urandom_range(0, known_cells.size() - 1)];
            cx = (p.x << 8) | $urandom_range(0, 255);
            cz = (p.z << 8) | $urandom_range(0, 255);
         end
         item.coord_x = cx[COORD_W-1:0];
         item.coord_z = cz[COORD_W-1:0];
         if (board.can_read(item)) begin
            send_request(item);
            return;
         end
      end
      send_random_write();
   endtask

   task automatic send_random_items(input int count);
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2:    send_random_write();
            3, 4, 5, 6: send_random_read(REQ_SAMPLE);
            7, 8:       send_random_read(REQ_POINT);
            default:    send_random_read(REQ_UNUSED);
         endcase
      end
   endtask

   task automatic run_phase(input int unsigned wreg, input int unsigned dreg, input int count);
      set_map_size(wreg, dreg);
      if (cur_w != 0 && cur_d != 0) fill_map();
      send_random_items(count);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty map after reset: every kind answers map-empty, writes store nothing.
      send_fields(REQ_WRITE, 'h100, 'h100, 16'hFFFF);
      send_fields(REQ_SAMPLE, 'h080, 'h040, 0);
      send_fields(REQ_POINT, -524288, 524287, 0);
      send_fields(REQ_UNUSED, 0, 0, 0);

      // Small 4 x 3 map, filled whole, then edges and special cases.
      run_phase(4, 3, 0);
      send_fields(REQ_WRITE, 'h0FF, 'h0FF, 16'hFFFF);   // fraction dropped: first cell
      send_fields(REQ_WRITE, 'h3FF, 'h2FF, 16'hFFFF);   // last cell
      send_fields(REQ_WRITE, 'h100, 'h000, 0);
      send_fields(REQ_WRITE, 4 << 8, 0, 16'h1234);      // column at the width
      send_fields(REQ_WRITE, 0, 3 << 8, 16'h1234);      // row at the depth
      send_fields(REQ_WRITE, -1, 0, 16'h1234);          // just below zero
      send_fields(REQ_WRITE, 0, -524288, 16'h1234);
      send_fields(REQ_WRITE, 524287, 524287, 16'h1234);
      send_fields(REQ_SAMPLE, 0, 0, 0);
      send_fields(REQ_SAMPLE, -524288, 524287, 16'hFFFF);
      send_fields(REQ_SAMPLE, 'h3FF, 'h2FF, 0);         // far neighbors clamp to last cell
      send_fields(REQ_SAMPLE, 'h0FF, 'h0FF, 0);
      send_fields(REQ_SAMPLE, 'h180, 'h080, 0);
      send_fields(REQ_SAMPLE, 4 << 8, 3 << 8, 0);       // exactly on the far edge
      send_fields(REQ_SAMPLE, 524287, -524288, 0);
      send_fields(REQ_POINT, -1, -1, 0);
      send_fields(REQ_POINT, 524287, 524287, 0);        // top height, full scale
      send_fields(REQ_POINT, 'h2FF, 'h1FF, 0);
      send_fields(REQ_POINT, 0, 0, 0);
      send_fields(REQ_UNUSED, 'h100, 'h200, 0);
      send_fields(REQ_UNUSED, -5, 1000, 0);

      // Random phases over a range of sizes, the largest and oversized
      // register values among them, and zero on either axis.
      run_phase(1, 1, 15);
      run_phase(2, 3, 25);
      run_phase(5, 7, 25);
      run_phase(16, 12, 30);
      run_phase(256, 256, 30);
      run_phase(511, 2, 20);
      run_phase(3, 300, 20);
      run_phase(13, 1, 15);
      run_phase(0, 9, 5);
      run_phase(200, 0, 5);
      wait_idle();

      if (board.errors == 0 && board.pending() == 0) begin
         $display("clamped_bilinear_height_sampler_test: clean");
      end else begin
         $display("clamped_bilinear_height_sampler_test: errors");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest correct run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("clamped_bilinear_height_sampler_test: errors");
      $finish;
   end

endmodule
